[design/spcp_pkg.sv]
// Shared defaults and latency constants for the segment closest-points core.
package spcp_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  // Pipeline stages beyond the FRAC_BITS quotient stages of the three ratio dividers
  localparam int LAT_EXTRA       = 24;
  // Ratio dividers in the chain
  localparam int DIV_COUNT       = 3;

endpackage

[design/segment_pair_closest_points_core.sv]
// Top level of the closest-points core for two 3D segments.
//
// Takes segments a-b and c-d in signed fixed point and returns the nearest point on each
// with its position 0..1 along that segment. One request is accepted in every cycle: busy
// is always low and start alone accepts a request. Each result appears on done_o for one
// cycle; the receiver cannot hold results off and results come out in request order. The
// path runs through three pipelined ratio dividers of FRAC_BITS+1 stages each: one for
// the initial position on a-b, one per refining projection onto c-d and back onto a-b.
module segment_pair_closest_points_core #(
  parameter int COORD_WIDTH = spcp_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = spcp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] az_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_i,
  input  logic signed [COORD_WIDTH-1:0] bz_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic signed [COORD_WIDTH-1:0] cz_i,
  input  logic signed [COORD_WIDTH-1:0] dx_i,
  input  logic signed [COORD_WIDTH-1:0] dy_i,
  input  logic signed [COORD_WIDTH-1:0] dz_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] near_first_x_o,
  output logic signed [COORD_WIDTH-1:0] near_first_y_o,
  output logic signed [COORD_WIDTH-1:0] near_first_z_o,
  output logic        [FRAC_BITS:0]     param_first_o,
  output logic signed [COORD_WIDTH-1:0] near_second_x_o,
  output logic signed [COORD_WIDTH-1:0] near_second_y_o,
  output logic signed [COORD_WIDTH-1:0] near_second_z_o,
  output logic        [FRAC_BITS:0]     param_second_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int DW  = CW + 1;
  localparam int XW  = 2 * DW + 1;
  localparam int NT  = 2 * XW + 3;
  localparam int LAT = spcp_pkg::DIV_COUNT * FB + spcp_pkg::LAT_EXTRA;

  logic signed [CW-1:0]   a [3];
  logic signed [CW-1:0]   b [3];
  logic signed [CW-1:0]   c [3];
  logic signed [CW-1:0]   d [3];
  logic signed [DW-1:0]   v_q [3];
  logic signed [DW-1:0]   u_q [3];
  logic signed [DW-1:0]   e_q [3];
  logic signed [2*DW-1:0] wa [3];
  logic signed [2*DW-1:0] wb [3];
  logic signed [2*DW-1:0] xa [3];
  logic signed [2*DW-1:0] xb [3];
  logic signed [XW-1:0]   w_q [3];
  logic signed [XW-1:0]   x_q [3];
  logic signed [2*XW-1:0] pww [3];
  logic signed [2*XW-1:0] pxw [3];
  logic signed [NT-1:0]   ww_s;
  logic signed [NT-1:0]   xw_s;
  logic signed [NT-1:0]   nxw_q;
  logic        [NT-1:0]   ww_q;
  logic                   wwz_q;
  logic                   wwz_dly;
  logic        [FB:0]     q0;
  logic        [FB:0]     t0;
  logic [6*CW-1:0]        ab_pk;
  logic [6*CW-1:0]        cd_pk;
  logic [6*CW-1:0]        ab1_dly;
  logic [6*CW-1:0]        ab2_dly;
  logic [6*CW-1:0]        cd_dly;
  logic signed [CW-1:0]   a1 [3];
  logic signed [CW-1:0]   b1 [3];
  logic signed [CW-1:0]   a2 [3];
  logic signed [CW-1:0]   b2 [3];
  logic signed [CW-1:0]   c1 [3];
  logic signed [CW-1:0]   d1 [3];
  logic signed [CW-1:0]   p0i [3];
  logic        [FB:0]     t0i;
  logic signed [CW-1:0]   p1 [3];
  logic        [FB:0]     t1;
  logic signed [CW-1:0]   p0f [3];
  logic        [FB:0]     t0f;
  logic [3*CW+FB:0]       p1_pk;
  logic [3*CW+FB:0]       p1_dly;
  logic [LAT-1:0]         vld_q;

  assign a[0] = ax_i;
  assign a[1] = ay_i;
  assign a[2] = az_i;
  assign b[0] = bx_i;
  assign b[1] = by_i;
  assign b[2] = bz_i;
  assign c[0] = cx_i;
  assign c[1] = cy_i;
  assign c[2] = cz_i;
  assign d[0] = dx_i;
  assign d[1] = dy_i;
  assign d[2] = dz_i;

  // Never stall: a request enters on every start
  assign busy = 1'b0;

  // Advance the valid bits alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start && !busy};
    end
  end

  // Segment directions and offset between the starts
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      v_q[k] <= DW'(b[k]) - DW'(a[k]);
      u_q[k] <= DW'(d[k]) - DW'(c[k]);
      e_q[k] <= DW'(a[k]) - DW'(c[k]);
    end
  end

  // Cross products v x u and e x u
  for (genvar k = 0; k < 3; k++) begin : g_cross
    localparam int I1 = (k + 1) % 3;
    localparam int I2 = (k + 2) % 3;

    spcp_mul #(.AW(DW), .BW(DW)) u_wa (
      .clk_i (clk_i), .a_i (v_q[I1]), .b_i (u_q[I2]), .p_o (wa[k])
    );
    spcp_mul #(.AW(DW), .BW(DW)) u_wb (
      .clk_i (clk_i), .a_i (v_q[I2]), .b_i (u_q[I1]), .p_o (wb[k])
    );
    spcp_mul #(.AW(DW), .BW(DW)) u_xa (
      .clk_i (clk_i), .a_i (e_q[I1]), .b_i (u_q[I2]), .p_o (xa[k])
    );
    spcp_mul #(.AW(DW), .BW(DW)) u_xb (
      .clk_i (clk_i), .a_i (e_q[I2]), .b_i (u_q[I1]), .p_o (xb[k])
    );

    always_ff @(posedge clk_i) begin
      w_q[k] <= XW'(wa[k]) - XW'(wb[k]);
      x_q[k] <= XW'(xa[k]) - XW'(xb[k]);
    end

    spcp_mul #(.AW(XW), .BW(XW)) u_ww (
      .clk_i (clk_i), .a_i (w_q[k]), .b_i (w_q[k]), .p_o (pww[k])
    );
    spcp_mul #(.AW(XW), .BW(XW)) u_xw (
      .clk_i (clk_i), .a_i (x_q[k]), .b_i (w_q[k]), .p_o (pxw[k])
    );
  end

  // Dot products w.w and -(x.w)
  always_comb begin
    ww_s = NT'(pww[0]) + NT'(pww[1]) + NT'(pww[2]);
    xw_s = NT'(pxw[0]) + NT'(pxw[1]) + NT'(pxw[2]);
  end

  always_ff @(posedge clk_i) begin
    ww_q  <= $unsigned(ww_s);
    nxw_q <= -xw_s;
    wwz_q <= ww_s == '0;
  end

  spcp_div #(.NW(NT), .FB(FB)) u_div0 (
    .clk_i (clk_i),
    .num_i (nxw_q),
    .den_i (ww_q),
    .q_o   (q0)
  );

  spcp_dly #(.W(1), .N(FB + 1)) u_wwz_dly (
    .clk_i (clk_i),
    .d_i   (wwz_q),
    .q_o   (wwz_dly)
  );

  // Parallel segments start from position zero
  assign t0 = wwz_dly ? '0 : q0;

  // Carry the endpoints to each stage that needs them
  for (genvar k = 0; k < 3; k++) begin : g_pack
    assign ab_pk[k*CW +: CW]     = a[k];
    assign ab_pk[(3+k)*CW +: CW] = b[k];
    assign cd_pk[k*CW +: CW]     = c[k];
    assign cd_pk[(3+k)*CW +: CW] = d[k];
    assign a1[k] = ab1_dly[k*CW +: CW];
    assign b1[k] = ab1_dly[(3+k)*CW +: CW];
    assign a2[k] = ab2_dly[k*CW +: CW];
    assign b2[k] = ab2_dly[(3+k)*CW +: CW];
    assign c1[k] = cd_dly[k*CW +: CW];
    assign d1[k] = cd_dly[(3+k)*CW +: CW];
    assign p1_pk[k*CW +: CW] = p1[k];
  end
  assign p1_pk[3*CW +: FB+1] = t1;

  spcp_dly #(.W(6 * CW), .N(FB + 8)) u_ab1_dly (
    .clk_i (clk_i), .d_i (ab_pk), .q_o (ab1_dly)
  );

  spcp_dly #(.W(6 * CW), .N(2 * FB + 17)) u_ab2_dly (
    .clk_i (clk_i), .d_i (ab_pk), .q_o (ab2_dly)
  );

  spcp_dly #(.W(6 * CW), .N(FB + 10)) u_cd_dly (
    .clk_i (clk_i), .d_i (cd_pk), .q_o (cd_dly)
  );

  // Initial point on a-b
  spcp_mix #(.CW(CW), .FB(FB)) u_mix0 (
    .clk_i  (clk_i),
    .s_i    (a1),
    .e_i    (b1),
    .t_i    (t0),
    .hold_i (1'b0),
    .r_o    (p0i),
    .t_o    (t0i)
  );

  // Refine onto c-d
  spcp_proj #(.CW(CW), .FB(FB)) u_proj_cd (
    .clk_i (clk_i),
    .p_i   (p0i),
    .s_i   (c1),
    .e_i   (d1),
    .r_o   (p1),
    .t_o   (t1)
  );

  // Refine back onto a-b
  spcp_proj #(.CW(CW), .FB(FB)) u_proj_ab (
    .clk_i (clk_i),
    .p_i   (p1),
    .s_i   (a2),
    .e_i   (b2),
    .r_o   (p0f),
    .t_o   (t0f)
  );

  spcp_dly #(.W(3 * CW + FB + 1), .N(FB + 7)) u_p1_dly (
    .clk_i (clk_i), .d_i (p1_pk), .q_o (p1_dly)
  );

  // Drive the result
  assign done_o          = vld_q[LAT-1];
  assign near_first_x_o  = p0f[0];
  assign near_first_y_o  = p0f[1];
  assign near_first_z_o  = p0f[2];
  assign param_first_o   = t0f;
  assign near_second_x_o = p1_dly[0 +: CW];
  assign near_second_y_o = p1_dly[CW +: CW];
  assign near_second_z_o = p1_dly[2*CW +: CW];
  assign param_second_o  = p1_dly[3*CW +: FB+1];

endmodule

[design/spcp_dly.sv]
// Fixed-length register delay line for payload bundles.
module spcp_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [N];

  // Shift the bundle one stage per cycle
  always_ff @(posedge clk_i) begin
    tap_q[0] <= d_i;
    for (int k = 1; k < N; k++) begin
      tap_q[k] <= tap_q[k-1];
    end
  end

  assign q_o = tap_q[N-1];

endmodule

[design/spcp_mul.sv]
// Two-stage signed multiplier built from four half-width partial products.
module spcp_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                    clk_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int LA = AW / 2;
  localparam int HA = AW - LA;
  localparam int LB = BW / 2;
  localparam int HB = BW - LB;
  localparam int PW = AW + BW;

  logic        [LA-1:0]    a_lo;
  logic signed [HA-1:0]    a_hi;
  logic        [LB-1:0]    b_lo;
  logic signed [HB-1:0]    b_hi;
  logic        [LA+LB-1:0] ll_q;
  logic signed [LA+HB:0]   lh_q;
  logic signed [HA+LB:0]   hl_q;
  logic signed [HA+HB-1:0] hh_q;
  logic signed [PW-1:0]    p_d;
  logic signed [PW-1:0]    p_q;

  assign a_lo = a_i[LA-1:0];
  assign a_hi = a_i[AW-1:LA];
  assign b_lo = b_i[LB-1:0];
  assign b_hi = b_i[BW-1:LB];

  // Form partial products
  always_ff @(posedge clk_i) begin
    ll_q <= a_lo * b_lo;
    lh_q <= $signed({1'b0, a_lo}) * b_hi;
    hl_q <= a_hi * $signed({1'b0, b_lo});
    hh_q <= a_hi * b_hi;
  end

  // Align and sum partial products
  always_comb begin
    p_d = PW'(ll_q) + (PW'(lh_q) << LB) + (PW'(hl_q) << LA) + (PW'(hh_q) << (LA + LB));
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

[design/spcp_div.sv]
// Pipelined restoring ratio divider: num/den clamped to 0..1 in Q1.FB.
module spcp_div #(
  parameter int NW = 70,
  parameter int FB = 16
) (
  input  logic                 clk_i,
  input  logic signed [NW-1:0] num_i,
  input  logic        [NW-1:0] den_i,
  output logic        [FB:0]   q_o
);

  logic [NW-1:0] rem_q [FB+1];
  logic [NW-1:0] den_q [FB+1];
  logic [FB-1:0] quo_q [FB+1];
  logic          pos_q [FB+1];
  logic          ge_q  [FB+1];

  // Classify the numerator: not positive, at least den, or a true fraction
  always_ff @(posedge clk_i) begin
    rem_q[0] <= $unsigned(num_i);
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    pos_q[0] <= !num_i[NW-1] && (num_i != '0);
    ge_q[0]  <= $unsigned(num_i) >= den_i;
  end

  // One quotient bit per stage
  for (genvar k = 1; k <= FB; k++) begin : g_step
    logic [NW:0] sh;
    logic [NW:0] dif;
    logic        take;

    always_comb begin
      sh   = {rem_q[k-1], 1'b0};
      dif  = sh - {1'b0, den_q[k-1]};
      take = !dif[NW];
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? dif[NW-1:0] : sh[NW-1:0];
      quo_q[k] <= {quo_q[k-1][FB-2:0], take};
      den_q[k] <= den_q[k-1];
      pos_q[k] <= pos_q[k-1];
      ge_q[k]  <= ge_q[k-1];
    end
  end

  // Clamp to zero or one, or pass the fractional quotient
  always_comb begin
    if (!pos_q[FB]) begin
      q_o = '0;
    end else if (ge_q[FB]) begin
      q_o = {1'b1, {FB{1'b0}}};
    end else begin
      q_o = {1'b0, quo_q[FB]};
    end
  end

endmodule

[design/spcp_mix.sv]
// Point on segment s-e at parameter t, truncated toward zero; two stages.
module spcp_mix #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                 clk_i,
  input  logic signed [CW-1:0] s_i [3],
  input  logic signed [CW-1:0] e_i [3],
  input  logic        [FB:0]   t_i,
  input  logic                 hold_i,
  output logic signed [CW-1:0] r_o [3],
  output logic        [FB:0]   t_o
);

  localparam int DW = CW + 1;
  localparam int PW = DW + FB + 2;

  logic signed [PW-1:0] prod_q [3];
  logic signed [CW-1:0] s_q    [3];
  logic signed [CW-1:0] r_q    [3];
  logic        [FB:0]   t_q;
  logic        [FB:0]   tr_q;
  logic                 hold_q;

  // Scale the segment direction by t
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      prod_q[k] <= (DW'(e_i[k]) - DW'(s_i[k])) * $signed({1'b0, t_i});
      s_q[k]    <= s_i[k];
    end
    t_q    <= t_i;
    hold_q <= hold_i;
  end

  // Drop fraction bits toward zero and offset from the start point
  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic signed [PW-1:0] rnd;
    logic signed [PW-1:0] sh;

    always_comb begin
      rnd = prod_q[k] + $signed({{(PW-FB){1'b0}}, {FB{prod_q[k][PW-1]}}});
      sh  = rnd >>> FB;
    end

    always_ff @(posedge clk_i) begin
      r_q[k] <= hold_q ? s_q[k] : s_q[k] + sh[CW-1:0];
    end

    assign r_o[k] = r_q[k];
  end

  // Degenerate segment reports one half
  always_ff @(posedge clk_i) begin
    tr_q <= hold_q ? {2'b01, {(FB-1){1'b0}}} : t_q;
  end

  assign t_o = tr_q;

endmodule

[design/spcp_proj.sv]
// Projection of a point onto a segment: dot products, ratio, mix.
module spcp_proj #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                 clk_i,
  input  logic signed [CW-1:0] p_i [3],
  input  logic signed [CW-1:0] s_i [3],
  input  logic signed [CW-1:0] e_i [3],
  output logic signed [CW-1:0] r_o [3],
  output logic        [FB:0]   t_o
);

  localparam int DW = CW + 1;
  localparam int NW = 2 * DW + 2;

  logic signed [DW-1:0]   se_q [3];
  logic signed [DW-1:0]   ps_q [3];
  logic signed [2*DW-1:0] sq   [3];
  logic signed [2*DW-1:0] pr   [3];
  logic signed [NW-1:0]   num_q;
  logic        [NW-1:0]   den_q;
  logic                   dz_q;
  logic                   dz_dly;
  logic        [FB:0]     q;
  logic [6*CW-1:0]        se_pk;
  logic [6*CW-1:0]        se_dly;
  logic signed [CW-1:0]   s_d  [3];
  logic signed [CW-1:0]   e_d  [3];

  // Direction and offset vectors
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      se_q[k] <= DW'(e_i[k]) - DW'(s_i[k]);
      ps_q[k] <= DW'(p_i[k]) - DW'(s_i[k]);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_dot
    spcp_mul #(.AW(DW), .BW(DW)) u_sq (
      .clk_i (clk_i),
      .a_i   (se_q[k]),
      .b_i   (se_q[k]),
      .p_o   (sq[k])
    );
    spcp_mul #(.AW(DW), .BW(DW)) u_pr (
      .clk_i (clk_i),
      .a_i   (ps_q[k]),
      .b_i   (se_q[k]),
      .p_o   (pr[k])
    );
    assign se_pk[k*CW +: CW]     = s_i[k];
    assign se_pk[(3+k)*CW +: CW] = e_i[k];
    assign s_d[k] = se_dly[k*CW +: CW];
    assign e_d[k] = se_dly[(3+k)*CW +: CW];
  end

  // Sum the dot products
  always_ff @(posedge clk_i) begin
    num_q <= NW'(pr[0]) + NW'(pr[1]) + NW'(pr[2]);
    den_q <= $unsigned(NW'(sq[0]) + NW'(sq[1]) + NW'(sq[2]));
    dz_q  <= (NW'(sq[0]) + NW'(sq[1]) + NW'(sq[2])) == '0;
  end

  spcp_div #(.NW(NW), .FB(FB)) u_div (
    .clk_i (clk_i),
    .num_i (num_q),
    .den_i (den_q),
    .q_o   (q)
  );

  spcp_dly #(.W(1), .N(FB + 1)) u_dz_dly (
    .clk_i (clk_i),
    .d_i   (dz_q),
    .q_o   (dz_dly)
  );

  spcp_dly #(.W(6 * CW), .N(FB + 5)) u_se_dly (
    .clk_i (clk_i),
    .d_i   (se_pk),
    .q_o   (se_dly)
  );

  spcp_mix #(.CW(CW), .FB(FB)) u_mix (
    .clk_i  (clk_i),
    .s_i    (s_d),
    .e_i    (e_d),
    .t_i    (q),
    .hold_i (dz_dly),
    .r_o    (r_o),
    .t_o    (t_o)
  );

endmodule

[design/spcp_chk.sv]
// Port-level checker for the closest-points core, bound to the top level.
module spcp_chk #(
  parameter int COORD_WIDTH = spcp_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = spcp_pkg::FRAC_BITS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 done_o,
  input logic [FRAC_BITS:0]   param_first_o,
  input logic [FRAC_BITS:0]   param_second_o
);

  localparam int LAT = spcp_pkg::DIV_COUNT * FRAC_BITS + spcp_pkg::LAT_EXTRA;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // The pipeline takes a request every cycle
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy == 1'b0)
    else $error("busy raised");

  // Each result traces back to a request a fixed latency earlier
  a_done_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("result without request");

  // Positions stay within one
  a_first_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> param_first_o <= ONE)
    else $error("param_first above one");

  a_second_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> param_second_o <= ONE)
    else $error("param_second above one");

endmodule

bind segment_pair_closest_points_core spcp_chk #(
  .COORD_WIDTH (COORD_WIDTH),
  .FRAC_BITS   (FRAC_BITS)
) u_spcp_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .param_first_o  (param_first_o),
  .param_second_o (param_second_o)
);

[tb/segment_pair_closest_points_core_tb.sv]
// Self-checking testbench for the segment-pair closest-points core.
`timescale 1ns / 100ps

module segment_pair_closest_points_core_tb;

  localparam int CW = spcp_pkg::COORD_WIDTH_DEF;
  localparam int FB = spcp_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = 3 * FB + spcp_pkg::LAT_EXTRA;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [FB:0] ONE_Q = (FB+1)'(1) << FB;
  localparam logic [FB:0] HALF_Q = (FB+1)'(1) << (FB - 1);

  typedef logic signed [255:0] wide_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t p0x, p0y, p0z;
    logic [FB:0] t0;
    coord_t p1x, p1y, p1z;
    logic [FB:0] t1;
  } closest_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t ax_i = '0, ay_i = '0, az_i = '0, bx_i = '0, by_i = '0, bz_i = '0;
  coord_t cx_i = '0, cy_i = '0, cz_i = '0, dx_i = '0, dy_i = '0, dz_i = '0;
  logic done_o;
  coord_t nfx, nfy, nfz, nsx, nsy, nsz;
  logic [FB:0] pf, ps;

  closest_t closest_q[$];
  int mismatches = 0;
  int cycles = 0;

  segment_pair_closest_points_core i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .ax_i(ax_i), .ay_i(ay_i), .az_i(az_i), .bx_i(bx_i), .by_i(by_i), .bz_i(bz_i),
    .cx_i(cx_i), .cy_i(cy_i), .cz_i(cz_i), .dx_i(dx_i), .dy_i(dy_i), .dz_i(dz_i),
    .done_o(done_o),
    .near_first_x_o(nfx), .near_first_y_o(nfy), .near_first_z_o(nfz),
    .param_first_o(pf),
    .near_second_x_o(nsx), .near_second_y_o(nsy), .near_second_z_o(nsz),
    .param_second_o(ps)
  );

  // Generate clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Clamp num/den to 0..one, truncated
  function automatic logic [FB:0] clamp_ratio(wide_t num, wide_t den);
    wide_t q;
    if (num <= 0) return '0;
    if (num >= den) return ONE_Q;
    q = (num <<< FB) / den;
    return q[FB:0];
  endfunction

  // Point s + trunc((e-s)*t / one)
  function automatic wide_t lerp(wide_t s, wide_t e, logic [FB:0] t);
    wide_t p;
    p = (e - s) * $signed({1'b0, t});
    p = p / (wide_t'(1) <<< FB);
    return s + p;
  endfunction

  function automatic wide_t dot3(wide_t a[3], wide_t b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  // Project p onto s-e; return parameter, point in r
  function automatic logic [FB:0] project(wide_t p[3], wide_t s[3], wide_t e[3],
                                          output wide_t r[3]);
    wide_t se[3], pd[3];
    wide_t den;
    logic [FB:0] t;
    for (int i = 0; i < 3; i++) begin
      se[i] = e[i] - s[i];
      pd[i] = p[i] - s[i];
    end
    den = dot3(se, se);
    if (den == 0) begin
      r = s;
      return HALF_Q;
    end
    t = clamp_ratio(dot3(pd, se), den);
    for (int i = 0; i < 3; i++) r[i] = lerp(s[i], e[i], t);
    return t;
  endfunction

  function automatic closest_t predict_closest(coord_t pts[12]);
    wide_t a[3], b[3], c[3], d[3], v[3], u[3], w[3], e[3], x[3], p0[3], p1[3];
    wide_t ww;
    logic [FB:0] t0, t1;
    closest_t r;
    for (int i = 0; i < 3; i++) begin
      a[i] = pts[i]; b[i] = pts[3+i]; c[i] = pts[6+i]; d[i] = pts[9+i];
      v[i] = b[i] - a[i]; u[i] = d[i] - c[i]; e[i] = a[i] - c[i];
    end
    if (v[0] == 0 && v[1] == 0 && v[2] == 0) begin
      t0 = HALF_Q; p0 = a;
      t1 = project(p0, c, d, p1);
    end else if (u[0] == 0 && u[1] == 0 && u[2] == 0) begin
      t1 = HALF_Q; p1 = c;
      t0 = project(p1, a, b, p0);
    end else begin
      w[0] = v[1]*u[2] - v[2]*u[1]; w[1] = v[2]*u[0] - v[0]*u[2];
      w[2] = v[0]*u[1] - v[1]*u[0];
      x[0] = e[1]*u[2] - e[2]*u[1]; x[1] = e[2]*u[0] - e[0]*u[2];
      x[2] = e[0]*u[1] - e[1]*u[0];
      ww = dot3(w, w);
      t0 = (ww == 0) ? '0 : clamp_ratio(-dot3(x, w), ww);
      for (int i = 0; i < 3; i++) p0[i] = lerp(a[i], b[i], t0);
      t1 = project(p0, c, d, p1);
      t0 = project(p1, a, b, p0);
    end
    r.p0x = p0[0][CW-1:0]; r.p0y = p0[1][CW-1:0]; r.p0z = p0[2][CW-1:0];
    r.p1x = p1[0][CW-1:0]; r.p1y = p1[1][CW-1:0]; r.p1z = p1[2][CW-1:0];
    r.t0 = t0; r.t1 = t1;
    return r;
  endfunction

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    closest_t got, exp_r;
    if (rst_ni && done_o) begin
      got = '{nfx, nfy, nfz, pf, nsx, nsy, nsz, ps};
      if (closest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = closest_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: exp %h got %h", exp_r, got);
        end
      end
    end
  end

  // Send one request, then release start unless another follows
  task automatic send_segments(coord_t pts[12], bit hold);
    ax_i <= pts[0]; ay_i <= pts[1]; az_i <= pts[2];
    bx_i <= pts[3]; by_i <= pts[4]; bz_i <= pts[5];
    cx_i <= pts[6]; cy_i <= pts[7]; cz_i <= pts[8];
    dx_i <= pts[9]; dy_i <= pts[10]; dz_i <= pts[11];
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    closest_q.push_back(predict_closest(pts));
    @(negedge clk_i);
    if (!hold) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 2000)) - 1000) <<< FB;
      2: return coord_t'($signed($urandom_range(0, 65535)) - 32768);
      default: return coord_t'($signed($urandom_range(0, 64)) - 32) <<< FB;
    endcase
  endfunction

  task automatic test_directed();
    coord_t p[12];
    coord_t extremes[4] = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh1};
    // Crossing segments
    p = '{0, 0, 0, 4 << FB, 0, 0, 2 << FB, -(1 << FB), 1 << FB, 2 << FB, 1 << FB,
          1 << FB};
    send_segments(p, 0);
    // Degenerate first, degenerate second, both degenerate
    p = '{1 << FB, 1 << FB, 1 << FB, 1 << FB, 1 << FB, 1 << FB, 0, 0, 0, 3 << FB, 0, 0};
    send_segments(p, 0);
    p = '{0, 0, 0, 3 << FB, 0, 0, 1 << FB, 1 << FB, 0, 1 << FB, 1 << FB, 0};
    send_segments(p, 0);
    p = '{5, 6, 7, 5, 6, 7, -9, 2, 3, -9, 2, 3};
    send_segments(p, 0);
    // Parallel and collinear segments
    p = '{0, 0, 0, 2 << FB, 0, 0, 0, 1 << FB, 0, 4 << FB, 1 << FB, 0};
    send_segments(p, 0);
    p = '{0, 0, 0, 2 << FB, 0, 0, 5 << FB, 0, 0, 3 << FB, 0, 0};
    send_segments(p, 0);
    // Field extremes
    for (int k = 0; k < 16; k++) begin
      foreach (p[i]) p[i] = extremes[(k + i * (k / 4 + 1)) % 4];
      send_segments(p, 0);
    end
    foreach (p[i]) p[i] = (i % 3 == 0) ? 32'sh80000000 : 32'sh7fffffff;
    send_segments(p, 0);
  endtask

  task automatic test_random(int count);
    coord_t p[12];
    int mode, sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && sent < count; b++) begin
        mode = $urandom_range(0, 3);
        foreach (p[i]) p[i] = rand_coord(mode);
        // Force occasional degenerate and parallel pairs
        case ($urandom_range(0, 9))
          0: begin p[3] = p[0]; p[4] = p[1]; p[5] = p[2]; end
          1: begin p[9] = p[6]; p[10] = p[7]; p[11] = p[8]; end
          2: for (int i = 0; i < 3; i++) p[9+i] = p[6+i] + (p[3+i] - p[i]) / 2;
          default: ;
        endcase
        sent++;
        send_segments(p, (b + 1 < burst) && (sent < count));
      end
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  endtask

  task automatic test_drain_pause();
    while (closest_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(500);
    test_drain_pause();
    test_random(650);
    while (closest_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
